>>> rtl/phph_pkg.sv
package phph_pkg;

    localparam int DEF_BINS_PER_SIDE = 32;
    localparam int DEF_COUNT_WIDTH   = 16;

    // pixel coordinate span after left/right placement: 0..1023
    localparam int COORD_BITS = 10;

    localparam logic FUNC_HIT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [1:0] KIND_HIT    = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [6:0] LANE_FIRST = 7'd32;
    localparam logic [6:0] LANE_END   = 7'd80;

    // chip id per lane offset (lane - 32); offsets 48..63 are never used
    localparam logic [5:0] LANE_CHIP [64] = '{
        6'd20, 6'd23, 6'd22, 6'd21, 6'd18, 6'd19, 6'd16, 6'd1,
        6'd0,  6'd3,  6'd2,  6'd5,  6'd4,  6'd7,  6'd6,  6'd9,
        6'd8,  6'd11, 6'd10, 6'd13, 6'd12, 6'd15, 6'd14, 6'd17,
        6'd44, 6'd47, 6'd46, 6'd45, 6'd42, 6'd43, 6'd40, 6'd25,
        6'd24, 6'd27, 6'd26, 6'd29, 6'd28, 6'd31, 6'd30, 6'd33,
        6'd32, 6'd35, 6'd34, 6'd37, 6'd36, 6'd39, 6'd38, 6'd41,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
    };

    // layer per chip id; ids 48..63 are never used
    localparam logic [4:0] CHIP_LAYER [64] = '{
        5'd22, 5'd22, 5'd20, 5'd20, 5'd18, 5'd18, 5'd16, 5'd16,
        5'd14, 5'd14, 5'd12, 5'd12, 5'd10, 5'd10, 5'd8,  5'd8,
        5'd6,  5'd6,  5'd4,  5'd4,  5'd0,  5'd0,  5'd2,  5'd2,
        5'd23, 5'd23, 5'd21, 5'd21, 5'd19, 5'd19, 5'd17, 5'd17,
        5'd15, 5'd15, 5'd13, 5'd13, 5'd11, 5'd11, 5'd9,  5'd9,
        5'd7,  5'd7,  5'd5,  5'd5,  5'd1,  5'd1,  5'd3,  5'd3,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };

    // control that travels with an item from the locate stages to the bin memory
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       left;
        logic       wr;
        logic [9:0] idx;
    } loc_ctl_t;

endpackage

>>> rtl/phph_in_if.sv
interface phph_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [6:0] lane_number;
    logic [9:0] pixel_column;
    logic [8:0] pixel_row;
    logic [9:0] read_bin;

    modport source (output valid, func, lane_number, pixel_column, pixel_row, read_bin,
                    input ready);
    modport sink   (input valid, func, lane_number, pixel_column, pixel_row, read_bin,
                    output ready);
endinterface

>>> rtl/phph_out_if.sv
interface phph_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [9:0]  bin_index;
    logic [15:0] bin_count;
    logic        left_side;

    modport source (output valid, result_kind, bin_index, bin_count, left_side,
                    input ready);
    modport sink   (input valid, result_kind, bin_index, bin_count, left_side,
                    output ready);
endinterface

>>> rtl/phph_locate.sv
module phph_locate #(
    parameter int BINS_PER_SIDE = phph_pkg::DEF_BINS_PER_SIDE,
    localparam int NUM_BINS = BINS_PER_SIDE * BINS_PER_SIDE,
    localparam int IW = $clog2(NUM_BINS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              take,
    input  logic              func,
    input  logic [6:0]        lane_number,
    input  logic [9:0]        pixel_column,
    input  logic [8:0]        pixel_row,
    input  logic [9:0]        read_bin,
    output phph_pkg::loc_ctl_t ctl,
    output logic [IW-1:0]     addr
);
    import phph_pkg::*;

    localparam int SW = $clog2(BINS_PER_SIDE);
    localparam int PW = COORD_BITS + $clog2(BINS_PER_SIDE + 1);
    localparam int WW = (IW > 10) ? IW : 10;
    localparam logic RD_ALWAYS = (NUM_BINS >= 1024);

    logic [5:0]          lane_off;
    logic [5:0]          chip;
    logic [4:0]          layer;
    logic                lane_ok;
    logic                left;
    logic [9:0]          coord_x;
    logic [9:0]          coord_y;
    logic [PW-1:0]       prod_x;
    logic [PW-1:0]       prod_y;
    logic [1:0]          kind_next;

    logic                s2_valid_reg;
    logic [1:0]          s2_kind_reg;
    logic                s2_left_reg;
    logic [SW-1:0]       s2_sx_reg;
    logic [SW-1:0]       s2_sy_reg;
    logic [9:0]          s2_rbin_reg;

    logic [IW-1:0]       hit_index;
    logic [WW-1:0]       hit_wide;
    logic                rd_in_range;
    loc_ctl_t            s3_ctl_next;
    logic [IW-1:0]       s3_addr_next;
    loc_ctl_t            s3_ctl_reg;
    logic [IW-1:0]       s3_addr_reg;

    // lane -> chip -> layer, then place the hit on the left or mirrored right
    always_comb
    begin
        lane_ok  = (lane_number >= LANE_FIRST) && (lane_number < LANE_END);
        lane_off = 6'(lane_number - LANE_FIRST);
        chip     = LANE_CHIP[lane_off];
        layer    = CHIP_LAYER[chip];
        left     = chip[0] ^ layer[0];
        if (left)
        begin
            coord_x = pixel_column;
            coord_y = {1'b1, pixel_row};
        end
        else
        begin
            coord_x = ~pixel_column;
            coord_y = {1'b0, ~pixel_row};
        end
        prod_x = PW'(coord_x) * PW'(BINS_PER_SIDE);
        prod_y = PW'(coord_y) * PW'(BINS_PER_SIDE);
        if (func == FUNC_READ)
            kind_next = KIND_READ;
        else if (lane_ok)
            kind_next = KIND_HIT;
        else
            kind_next = KIND_REJECT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= kind_next;
            s2_left_reg <= left;
            s2_sx_reg   <= SW'(prod_x >> COORD_BITS);
            s2_sy_reg   <= SW'(prod_y >> COORD_BITS);
            s2_rbin_reg <= read_bin;
        end
    end

    // row-major bin address
    always_comb
    begin
        hit_index   = IW'(s2_sy_reg) * IW'(BINS_PER_SIDE) + IW'(s2_sx_reg);
        hit_wide    = WW'(hit_index);
        rd_in_range = RD_ALWAYS || ({1'b0, s2_rbin_reg} < 11'(NUM_BINS));
        s3_ctl_next.valid = s2_valid_reg;
        s3_ctl_next.kind  = s2_kind_reg;
        case (s2_kind_reg)
            KIND_HIT:
            begin
                s3_addr_next     = hit_index;
                s3_ctl_next.idx  = hit_wide[9:0];
                s3_ctl_next.wr   = 1'b1;
                s3_ctl_next.left = s2_left_reg;
            end
            KIND_READ:
            begin
                s3_addr_next     = IW'(s2_rbin_reg);
                s3_ctl_next.idx  = s2_rbin_reg;
                s3_ctl_next.wr   = rd_in_range;
                s3_ctl_next.left = 1'b0;
            end
            default:
            begin
                s3_addr_next     = '0;
                s3_ctl_next.idx  = '0;
                s3_ctl_next.wr   = 1'b0;
                s3_ctl_next.left = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg  <= '0;
            s3_addr_reg <= '0;
        end
        else if (adv)
        begin
            s3_ctl_reg  <= s3_ctl_next;
            s3_addr_reg <= s3_addr_next;
        end
    end

    assign ctl  = s3_ctl_reg;
    assign addr = s3_addr_reg;

endmodule

>>> rtl/pixel_hit_projection_histogram.sv
// channel    | dir | transfer payload
// -----------+-----+-----------------------------------------------------------
// hit_in     | in  | func, lane_number, pixel_column, pixel_row, read_bin
// result_out | out | result_kind, bin_index, bin_count, left_side
//
// Four register stages, the first loaded at the input transfer edge: lane lookup
// and scale, bin address, memory read, update into the output register. One
// item per cycle is sustained while result_out is ready, and a back-to-back hit
// on the same bin takes the updated count by forwarding. After reset a clearing
// pass writes zero to every bin (1024 at default), one per cycle, with
// hit_in.ready low. The whole pipeline holds while a result waits on result_out.
module pixel_hit_projection_histogram #(
    parameter int BINS_PER_SIDE = phph_pkg::DEF_BINS_PER_SIDE,
    parameter int COUNT_WIDTH   = phph_pkg::DEF_COUNT_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    phph_in_if.sink           hit_in,
    phph_out_if.source        result_out
);
    import phph_pkg::*;

    localparam int NUM_BINS = BINS_PER_SIDE * BINS_PER_SIDE;
    localparam int IW = $clog2(NUM_BINS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // advance every stage unless a result is waiting to transfer
    logic                   adv;
    logic                   take;

    loc_ctl_t               s3_ctl;
    logic [IW-1:0]          s3_addr;

    // clearing pass after reset
    logic                   clr_active_reg;
    logic [IW-1:0]          clr_addr_reg;

    // bin memory
    logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    // read stage
    loc_ctl_t               s4_ctl_reg;
    logic [IW-1:0]          s4_addr_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   fwd_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;
    logic                   fwd_next;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [COUNT_WIDTH-1:0] res_count;
    logic [31:0]            res_wide;

    // output register
    logic                   out_valid_reg;
    logic [1:0]             out_kind_reg;
    logic [9:0]             out_index_reg;
    logic [15:0]            out_count_reg;
    logic                   out_left_reg;

    assign adv          = !out_valid_reg || result_out.ready;
    assign hit_in.ready = adv && !clr_active_reg;
    assign take         = hit_in.valid && hit_in.ready;

    phph_locate #(
        .BINS_PER_SIDE (BINS_PER_SIDE)
    ) u_locate (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .take         (take),
        .func         (hit_in.func),
        .lane_number  (hit_in.lane_number),
        .pixel_column (hit_in.pixel_column),
        .pixel_row    (hit_in.pixel_row),
        .read_bin     (hit_in.read_bin),
        .ctl          (s3_ctl),
        .addr         (s3_addr)
    );

    // Sweep zero through the memory once after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == IW'(NUM_BINS - 1))
                clr_active_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Pick the counter value the item sees: forwarded from the item just ahead
    // when it wrote the same bin, otherwise the memory read.
    always_comb
    begin
        cur_count = fwd_reg ? fwd_data_reg : rd_data_reg;
        case (s4_ctl_reg.kind)
            KIND_HIT:
            begin
                new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
                res_count = new_count;
            end
            KIND_READ:
            begin
                new_count = '0;
                res_count = s4_ctl_reg.wr ? cur_count : '0;
            end
            default:
            begin
                new_count = '0;
                res_count = '0;
            end
        endcase
        res_wide = 32'(res_count);
        fwd_next = s4_ctl_reg.valid && s4_ctl_reg.wr && (s4_addr_reg == s3_addr);
    end

    // Write port: clearing pass first, then the update of the item leaving.
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = adv && s4_ctl_reg.valid && s4_ctl_reg.wr;
            mem_waddr = s4_addr_reg;
            mem_wdata = new_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_waddr] <= mem_wdata;
        if (adv)
            rd_data_reg <= bin_mem[s3_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_ctl_reg    <= '0;
            s4_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_ctl_reg    <= s3_ctl;
            s4_addr_reg   <= s3_addr;
            out_valid_reg <= s4_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_reg         <= fwd_next;
            fwd_data_reg    <= new_count;
            out_kind_reg    <= s4_ctl_reg.kind;
            out_index_reg   <= s4_ctl_reg.idx;
            out_count_reg   <= res_wide[15:0];
            out_left_reg    <= s4_ctl_reg.left;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.result_kind = out_kind_reg;
    assign result_out.bin_index   = out_index_reg;
    assign result_out.bin_count   = out_count_reg;
    assign result_out.left_side   = out_left_reg;

    // A rejected hit reports no bin, no count and no side.
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_REJECT) |->
            (out_index_reg == '0 && out_count_reg == '0 && !out_left_reg))
        else $error("rejected hit carries bin data");

    // A read result never claims a side.
    a_read_no_side: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_READ) |-> !out_left_reg)
        else $error("read result has left_side set");

    // The clearing pass runs once and never restarts.
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clearing pass restarted");

    // No item may be inside the pipeline while the memory is being cleared.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s3_ctl.valid && !s4_ctl_reg.valid && !out_valid_reg))
        else $error("item in flight during clearing pass");

endmodule
